[design/iil_pkg.sv]
// Shared types and constants of the indexed insert/delete list.
`default_nettype none

package iil_pkg;

  localparam int unsigned CapacityDef    = 32;
  localparam int unsigned EntryWidthDef  = 32;
  localparam int unsigned ListLimit      = 32;
  localparam logic [31:0] CompareMaskRst = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_POS = 2'd1,
    ACT_DEL_VAL = 2'd2,
    ACT_LIST    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_INSWR,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

[design/indexed_insert_delete_list.sv]
// Indexed insert/delete list: one memory of entries plus a walk sequencer.
//
// Usage: an ordered list of up to CAPACITY entries held in one RAM. Each
// input transfer (action, position, value) is one command: insert at a
// position (a position past the end appends, a full list answers status
// full), delete at a position (a position not below the count answers
// status bad), delete every entry equal to value under compare_mask (an
// empty list answers status bad), or list all entries. Every command but a
// list answers with one result transfer marked last; a list gives one
// transfer per entry (at most 32) with its index, the final one marked last,
// or one empty transfer when the list holds nothing. entry_count always
// carries the count after the command.
// Timing: commands are taken one at a time. Shifting, compaction and listing
// move one entry per cycle through the RAM read port, save that a stalled
// result side holds the output register and, while listing, pauses the walk
// with the read data held in the RAM output register.
// Reset: count goes to zero and compare_mask to all ones at once; the RAM is
// not cleared, since only entries below the count are ever read.
// The user must write compare_mask through cfg_we_i/cfg_wdata_i only while
// the block idles; the block itself does not enforce this.
`default_nettype none

module indexed_insert_delete_list #(
  parameter int unsigned CAPACITY    = iil_pkg::CapacityDef,
  parameter int unsigned ENTRY_WIDTH = iil_pkg::EntryWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [31:0] value_i,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      element_o,
  output logic [4:0]       element_index_o,
  output logic             has_element_o,
  output logic             last_o,
  output logic [5:0]       entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  iil_pkg::state_e  state_q, state_d;
  iil_pkg::action_e op_q, op_d, act_in;

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  logic [31:0]            cmp_q, cmp_d;
  logic [31:0]            mask_q;
  logic [1:0]             status_q, status_d;
  logic [AW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]          rd_left_q, rd_left_d;
  logic [CW-1:0]          kept_q, kept_d;
  logic                   s1_vld_q, s1_vld_d;
  logic [AW-1:0]          s1_addr_q, s1_addr_d;

  logic                   out_vld_q;
  logic [1:0]             out_status_q;
  logic [31:0]            out_elem_q;
  logic [4:0]             out_idx_q;
  logic                   out_has_q, out_last_q;
  logic [5:0]             out_count_q;

  // RAM port
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]            rdata_ext;
  logic [31:0]            rdata32;

  // control
  logic          accept, out_free, stall, issue, walk_done, list_load, keep;
  logic          full, pos_past, del_ok;
  logic [CW-1:0] pos_in, pos_eff, ins_left, del_left, list_n;

  assign act_in    = iil_pkg::action_e'(action_i);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_vld_q || out_ready_i;
  assign rdata_ext = 64'(ram_rdata);
  assign rdata32   = rdata_ext[31:0];

  // command decode against the current count
  assign pos_in   = CW'(position_i);
  assign full     = count_q >= CW'(CAPACITY);
  assign pos_past = 32'(position_i) > 32'(count_q);
  assign del_ok   = 32'(position_i) < 32'(count_q);
  assign pos_eff  = pos_past ? count_q : pos_in;
  assign ins_left = count_q - pos_eff;
  assign del_left = count_q - pos_in - CW'(1);
  assign list_n   = (32'(count_q) > iil_pkg::ListLimit) ? CW'(iil_pkg::ListLimit) : count_q;

  // walk pipeline: stage 0 issues a read, stage 1 sees the data
  assign stall     = s1_vld_q && (op_q == iil_pkg::ACT_LIST) && !out_free;
  assign issue     = (state_q == iil_pkg::S_WALK) && (rd_left_q != '0) && !stall;
  assign walk_done = (state_q == iil_pkg::S_WALK) && (rd_left_q == '0) && !s1_vld_q;
  assign keep      = (rdata32 & mask_q) != (cmp_q & mask_q);
  assign list_load = (state_q == iil_pkg::S_WALK) && s1_vld_q &&
                     (op_q == iil_pkg::ACT_LIST) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iil_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (act_in)
            iil_pkg::ACT_INSERT: begin
              if (full) state_d = iil_pkg::S_RESP;
              else if (ins_left != '0) state_d = iil_pkg::S_WALK;
              else state_d = iil_pkg::S_INSWR;
            end
            iil_pkg::ACT_DEL_POS: begin
              if (del_ok && (del_left != '0)) state_d = iil_pkg::S_WALK;
              else state_d = iil_pkg::S_RESP;
            end
            iil_pkg::ACT_DEL_VAL,
            iil_pkg::ACT_LIST: begin
              if (count_q == '0) state_d = iil_pkg::S_RESP;
              else state_d = iil_pkg::S_WALK;
            end
            default: state_d = iil_pkg::S_RESP;
          endcase
        end
      end
      iil_pkg::S_WALK: begin
        if (walk_done) begin
          case (op_q)
            iil_pkg::ACT_INSERT: state_d = iil_pkg::S_INSWR;
            iil_pkg::ACT_LIST:   state_d = iil_pkg::S_IDLE;
            default:             state_d = iil_pkg::S_RESP;
          endcase
        end
      end
      iil_pkg::S_INSWR: state_d = iil_pkg::S_RESP;
      iil_pkg::S_RESP: begin
        if (out_free) state_d = iil_pkg::S_IDLE;
      end
      default: state_d = iil_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and RAM port
  always_comb begin
    in_ready_o = (state_q == iil_pkg::S_IDLE);
    ram_re     = issue;
    ram_raddr  = rd_ptr_q;
    ram_we     = 1'b0;
    ram_waddr  = s1_addr_q;
    ram_wdata  = ram_rdata;
    case (state_q)
      iil_pkg::S_WALK: begin
        if (s1_vld_q) begin
          case (op_q)
            iil_pkg::ACT_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = s1_addr_q + AW'(1);
            end
            iil_pkg::ACT_DEL_POS: begin
              ram_we    = 1'b1;
              ram_waddr = s1_addr_q - AW'(1);
            end
            iil_pkg::ACT_DEL_VAL: begin
              // compact survivors toward the front
              ram_we    = keep;
              ram_waddr = AW'(kept_q);
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      iil_pkg::S_INSWR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        ram_wdata = val_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cmp_d     = cmp_q;
    status_d  = status_q;
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    rd_left_d = rd_left_q;
    kept_d    = kept_q;
    s1_vld_d  = issue || (s1_vld_q && stall);
    s1_addr_d = issue ? rd_ptr_q : s1_addr_q;

    if (accept) begin
      op_d     = act_in;
      val_d    = ENTRY_WIDTH'(64'(value_i));
      cmp_d    = value_i;
      pos_d    = pos_eff;
      kept_d   = '0;
      status_d = iil_pkg::ST_OK;
      case (act_in)
        iil_pkg::ACT_INSERT: begin
          if (full) status_d = iil_pkg::ST_FULL;
          rd_ptr_d  = AW'(count_q - CW'(1));
          rd_left_d = ins_left;
        end
        iil_pkg::ACT_DEL_POS: begin
          rd_ptr_d  = AW'(pos_in + CW'(1));
          rd_left_d = del_left;
          if (!del_ok) begin
            status_d  = iil_pkg::ST_BAD;
            rd_left_d = '0;
          end else if (del_left == '0) begin
            // last entry goes: nothing to shift
            count_d = count_q - CW'(1);
          end
        end
        iil_pkg::ACT_DEL_VAL: begin
          if (count_q == '0) status_d = iil_pkg::ST_BAD;
          rd_ptr_d  = '0;
          rd_left_d = count_q;
        end
        iil_pkg::ACT_LIST: begin
          rd_ptr_d  = '0;
          rd_left_d = list_n;
        end
        default: rd_left_d = '0;
      endcase
    end

    if (issue) begin
      rd_left_d = rd_left_q - CW'(1);
      if (op_q == iil_pkg::ACT_INSERT) rd_ptr_d = rd_ptr_q - AW'(1);
      else rd_ptr_d = rd_ptr_q + AW'(1);
    end

    if (ram_we && (state_q == iil_pkg::S_WALK) && (op_q == iil_pkg::ACT_DEL_VAL)) begin
      kept_d = kept_q + CW'(1);
    end

    if (walk_done) begin
      case (op_q)
        iil_pkg::ACT_DEL_POS: count_d = count_q - CW'(1);
        iil_pkg::ACT_DEL_VAL: count_d = kept_q;
        default:              count_d = count_q;
      endcase
    end

    if (state_q == iil_pkg::S_INSWR) count_d = count_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= iil_pkg::S_IDLE;
      count_q   <= '0;
      mask_q    <= iil_pkg::CompareMaskRst;
      rd_left_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_left_q <= rd_left_d;
      s1_vld_q  <= s1_vld_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (list_load || ((state_q == iil_pkg::S_RESP) && out_free)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    cmp_q     <= cmp_d;
    status_q  <= status_d;
    rd_ptr_q  <= rd_ptr_d;
    kept_q    <= kept_d;
    s1_addr_q <= s1_addr_d;
    if (list_load) begin
      out_status_q <= iil_pkg::ST_OK;
      out_elem_q   <= rdata32;
      out_idx_q    <= 5'(s1_addr_q);
      out_has_q    <= 1'b1;
      out_last_q   <= (rd_left_q == '0);
      out_count_q  <= 6'(count_q);
    end else if ((state_q == iil_pkg::S_RESP) && out_free) begin
      out_status_q <= status_q;
      out_elem_q   <= '0;
      out_idx_q    <= '0;
      out_has_q    <= 1'b0;
      out_last_q   <= 1'b1;
      out_count_q  <= 6'(count_q);
    end
  end

  iil_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign element_o       = out_elem_q;
  assign element_index_o = out_idx_q;
  assign has_element_o   = out_has_q;
  assign last_o          = out_last_q;
  assign entry_count_o   = out_count_q;

  // the RAM is only touched by the walk and the final insert write
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iil_pkg::S_IDLE || state_q == iil_pkg::S_RESP) |-> !ram_we)
    else $error("RAM write outside a command");

  // walk reads and writes never meet at one entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write at the same entry");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count beyond capacity");

  a_stage_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (state_q == iil_pkg::S_WALK))
    else $error("read data pending outside a walk");

  a_list_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iil_pkg::S_WALK && op_q == iil_pkg::ACT_LIST) |=> $stable(count_q))
    else $error("count changed while listing");

endmodule

`default_nettype wire

[design/iil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the indexed insert/delete list: random-stalled command and result streams.
module tb;

  localparam int unsigned Capacity = iil_pkg::CapacityDef;

  // One command as the driver presents it.
  typedef struct {
    iil_pkg::action_e act;
    logic [7:0]       pos;
    logic [31:0]      val;
  } command_t;

  // One result transfer as the block should present it.
  typedef struct {
    iil_pkg::status_e status;
    logic [31:0]      element;
    logic [4:0]       element_index;
    logic             has_element;
    logic             last;
    logic [5:0]       entry_count;
  } outcome_t;

  // Clock, reset and every block input start at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cmd_valid = 1'b0;
  logic [1:0]  cmd_action = iil_pkg::ACT_LIST;
  logic [7:0]  cmd_position = '0;
  logic [31:0] cmd_value = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        out_ready = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [31:0] element_o;
  logic [4:0]  element_index_o;
  logic        has_element_o;
  logic        last_o;
  logic [5:0]  entry_count_o;

  // Shadow copy of the list, kept in step with every accepted command.
  logic [31:0] shadow_entries [Capacity];
  int          shadow_count = 0;
  logic [31:0] shadow_mask = iil_pkg::CompareMaskRst;

  command_t    cmd_queue [$];
  outcome_t    due_results [$];
  outcome_t    want;
  command_t    pending;
  logic [31:0] value_pool [8];
  int unsigned error_count = 0;

  // Handshake bookkeeping shared between the edges.
  logic        cmd_fire = 1'b0;
  logic        rsp_fire = 1'b0;
  logic        send_next;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  indexed_insert_delete_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (cmd_valid),
    .in_ready_o      (in_ready_o),
    .action_i        (cmd_action),
    .position_i      (cmd_position),
    .value_i         (cmd_value),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .status_o        (status_o),
    .element_o       (element_o),
    .element_index_o (element_index_o),
    .has_element_o   (has_element_o),
    .last_o          (last_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Draw an idle gap length between 0 and 10; now and then flip into or out of a
  // calm stretch where no gaps are inserted at all.
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Apply one accepted command to the shadow list and queue the results
  // it must produce.
  task automatic apply_command(input iil_pkg::action_e act, input logic [7:0] pos,
                               input logic [31:0] val);
    outcome_t r;
    int       p;
    int       kept;
    int       n;
    r.status        = iil_pkg::ST_OK;
    r.element       = '0;
    r.element_index = '0;
    r.has_element   = 1'b0;
    r.last          = 1'b1;
    case (act)
      iil_pkg::ACT_INSERT: begin
        if (shadow_count >= Capacity) begin
          r.status = iil_pkg::ST_FULL;
        end else begin
          // A position past the end appends.
          p = (int'(pos) > shadow_count) ? shadow_count : int'(pos);
          for (int i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[p] = val;
          shadow_count++;
        end
      end
      iil_pkg::ACT_DEL_POS: begin
        if (int'(pos) >= shadow_count) begin
          r.status = iil_pkg::ST_BAD;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      iil_pkg::ACT_DEL_VAL: begin
        if (shadow_count == 0) begin
          r.status = iil_pkg::ST_BAD;
        end else begin
          // Compact the survivors in order; every match goes, not just the first.
          kept = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if ((shadow_entries[i] & shadow_mask) != (val & shadow_mask)) begin
              shadow_entries[kept] = shadow_entries[i];
              kept++;
            end
          end
          shadow_count = kept;
        end
      end
      default: begin
        n = (shadow_count < iil_pkg::ListLimit) ? shadow_count : iil_pkg::ListLimit;
        r.entry_count = 6'(shadow_count);
        // An empty list still answers with one bare transfer.
        for (int i = 0; i < n; i++) begin
          r.element       = shadow_entries[i];
          r.element_index = 5'(i);
          r.has_element   = 1'b1;
          r.last          = (i + 1 == n);
          due_results.push_back(r);
        end
        if (n == 0) due_results.push_back(r);
        return;
      end
    endcase
    r.entry_count = 6'(shadow_count);
    due_results.push_back(r);
  endtask

  // Rising edge: note transfers, track the mask, predict and check.
  always @(posedge clk_i) begin
    cmd_fire <= rst_ni && cmd_valid && in_ready_o;
    rsp_fire <= rst_ni && out_valid_o && out_ready;
    if (rst_ni) begin
      if (cfg_we) shadow_mask = cfg_wdata;
      if (cmd_valid && in_ready_o) begin
        apply_command(iil_pkg::action_e'(cmd_action), cmd_position, cmd_value);
      end
      if (out_valid_o && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no result expected");
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (element_o !== want.element) begin
            $error("element: expected %h, got %h", want.element, element_o);
            error_count++;
          end
          if (element_index_o !== want.element_index) begin
            $error("element_index: expected %0d, got %0d", want.element_index,
                   element_index_o);
            error_count++;
          end
          if (has_element_o !== want.has_element) begin
            $error("has_element: expected %0d, got %0d", want.has_element, has_element_o);
            error_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            error_count++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
            error_count++;
          end
        end
      end
    end
  end

  // Command driver: hold valid and payload until the transfer, then drop
  // valid for a drawn gap before the next command. valid gets one update
  // per falling edge, so back-to-back commands keep it high.
  always @(negedge clk_i) begin
    send_next = cmd_valid;
    if (cmd_valid && cmd_fire) begin
      send_next = 1'b0;
      send_wait = draw_gap(send_calm);
    end
    if (!send_next) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (cmd_queue.size() > 0) begin
        pending = cmd_queue.pop_front();
        cmd_action   <= pending.act;
        cmd_position <= pending.pos;
        cmd_value    <= pending.val;
        send_next = 1'b1;
      end
    end
    cmd_valid <= send_next;
  end

  // Result side: after each transfer, stall ready for a drawn gap.
  always @(negedge clk_i) begin
    if (rsp_fire) recv_wait = draw_gap(recv_calm);
    if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_cmd(input iil_pkg::action_e act, input int unsigned pos,
                           input logic [31:0] val);
    cmd_queue.push_back('{act, 8'(pos), val});
  endtask

  // Mostly positions near the live range, sometimes anywhere in the field;
  // values mostly from a small pool so that delete by value finds matches.
  task automatic queue_random(input int unsigned count, input int unsigned insert_pct);
    iil_pkg::action_e act;
    int unsigned      roll;
    int unsigned      pos;
    logic [31:0]      val;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        act = iil_pkg::ACT_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        act = (roll < 40) ? iil_pkg::ACT_DEL_POS :
              (roll < 65) ? iil_pkg::ACT_DEL_VAL : iil_pkg::ACT_LIST;
      end
      pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 35);
      val = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 7)] : $urandom;
      queue_cmd(act, pos, val);
    end
  endtask

  // Wait until every command went out and every result came back, then let
  // the block finish any internal walk.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || cmd_valid || due_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [31:0] mask);
    wait_idle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list corners, inserts at front, middle, end and past
    // the end, rejected and accepted deletes, delete by value with and
    // without a match.
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);
    queue_cmd(iil_pkg::ACT_DEL_POS, 0, '0);
    queue_cmd(iil_pkg::ACT_DEL_VAL, 0, 32'h0);
    queue_cmd(iil_pkg::ACT_INSERT, 0, 32'h0000_0000);
    queue_cmd(iil_pkg::ACT_INSERT, 255, 32'hFFFF_FFFF);
    queue_cmd(iil_pkg::ACT_INSERT, 1, 32'hA5A5_A5A5);
    queue_cmd(iil_pkg::ACT_INSERT, 0, 32'h5A5A_5A5A);
    queue_cmd(iil_pkg::ACT_INSERT, 4, 32'h1234_5678);
    queue_cmd(iil_pkg::ACT_LIST, 255, 32'hFFFF_FFFF);
    queue_cmd(iil_pkg::ACT_DEL_POS, 255, '0);
    queue_cmd(iil_pkg::ACT_DEL_POS, 5, '0);
    queue_cmd(iil_pkg::ACT_DEL_POS, 0, '0);
    queue_cmd(iil_pkg::ACT_DEL_POS, 3, '0);
    queue_cmd(iil_pkg::ACT_DEL_VAL, 0, 32'hDEAD_BEEF);
    queue_cmd(iil_pkg::ACT_DEL_VAL, 0, 32'hA5A5_A5A5);
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);
    queue_cmd(iil_pkg::ACT_INSERT, 128, 32'h0000_00AA);
    queue_cmd(iil_pkg::ACT_INSERT, 0, 32'hFFFF_FFAA);

    // Compare the low byte only: both AA entries go at once.
    write_mask(32'h0000_00FF);
    queue_cmd(iil_pkg::ACT_DEL_VAL, 0, 32'h1234_56AA);
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);
    queue_random(30, 55);

    // Fill to capacity, bounce off the full list, then refill.
    write_mask(32'hFFFF_FFFF);
    repeat (36) begin
      queue_cmd(iil_pkg::ACT_INSERT, $urandom_range(0, 40), value_pool[$urandom_range(0, 7)]);
    end
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);
    queue_cmd(iil_pkg::ACT_INSERT, 0, $urandom);
    queue_cmd(iil_pkg::ACT_DEL_POS, 200, '0);
    queue_cmd(iil_pkg::ACT_DEL_POS, 31, '0);
    queue_cmd(iil_pkg::ACT_INSERT, 255, $urandom);
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);

    // An all-zero mask matches everything: clear the full list in one go.
    write_mask(32'h0000_0000);
    queue_cmd(iil_pkg::ACT_DEL_VAL, 0, $urandom);
    queue_cmd(iil_pkg::ACT_LIST, 0, '0);
    queue_random(28, 50);

    write_mask($urandom);
    queue_random(20, 50);

    write_mask(32'hF0F0_F0F0);
    queue_random(20, 45);

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS indexed_insert_delete_list");
    end else begin
      $display("FAIL indexed_insert_delete_list");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL indexed_insert_delete_list");
    $finish;
  end

endmodule

[indexed_insert_delete_list.f]
design/iil_pkg.sv
design/iil_ram.sv
design/indexed_insert_delete_list.sv
test/tb.sv
